// ----- rtl/core/leb_pkg.sv -----
// Shared constants, codes and types for the line edit buffer.
package leb_pkg;

    localparam int CAPACITY = 32;
    localparam int CNT_W    = 6;
    localparam int ADDR_W   = $clog2(CAPACITY);

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam logic [7:0] MARK_BYTE = 8'd35;

    localparam logic [2:0] FN_INSERT = 3'd0;
    localparam logic [2:0] FN_BKSP   = 3'd1;
    localparam logic [2:0] FN_DEL    = 3'd2;
    localparam logic [2:0] FN_LEFT   = 3'd3;
    localparam logic [2:0] FN_RIGHT  = 3'd4;
    localparam logic [2:0] FN_SHOW   = 3'd5;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_BOUND = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [7:0]       text_byte;
        logic             is_cursor;
        logic             last;
        logic [CNT_W-1:0] line_length;
        logic [CNT_W-1:0] cursor_pos;
        logic [1:0]       status;
    } res_word_t;

    typedef struct packed {
        logic      push;
        res_word_t word;
    } res_push_t;

endpackage

// ----- rtl/core/leb_if.sv -----
// Command and result channel interfaces of the line edit buffer.
interface leb_cmd_if import leb_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [7:0] ch;

    modport source (output valid, output func, output ch, input ready);
    modport sink (input valid, input func, input ch, output ready);
endinterface

interface leb_res_if import leb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [7:0]       text_byte;
    logic             is_cursor;
    logic             last;
    logic [CNT_W-1:0] line_length;
    logic [CNT_W-1:0] cursor_pos;
    logic [1:0]       status;

    modport source (output valid, output text_byte, output is_cursor, output last,
                    output line_length, output cursor_pos, output status, input ready);
    modport sink (input valid, input text_byte, input is_cursor, input last,
                  input line_length, input cursor_pos, input status, output ready);
endinterface

// ----- rtl/core/leb_ctrl.sv -----
// Command sequencer with text memory and shared index step unit.
module leb_ctrl import leb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  logic [2:0] cmd_func,
    input  logic [7:0] cmd_ch,
    input  logic      can_push,
    output res_push_t res_push
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_INS_RD   = 8'b0000_0010,
        S_INS_WR   = 8'b0000_0100,
        S_DEL_RD   = 8'b0000_1000,
        S_DEL_WR   = 8'b0001_0000,
        S_SHOW     = 8'b0010_0000,
        S_SHOW_DAT = 8'b0100_0000,
        S_RESULT   = 8'b1000_0000
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] len_reg, len_next;
    logic [CNT_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] src_reg, src_next;
    logic [1:0]       status_reg, status_next;
    logic [7:0]       ch_reg, ch_next;

    logic [7:0]       text_mem [CAPACITY];
    logic [7:0]       rdata_reg;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]       wdata;
    logic             mem_we;

    // shared step unit: operand plus or minus one
    logic [CNT_W-1:0] step_a;
    logic             step_dec;
    logic [CNT_W-1:0] step_y;

    logic [CNT_W-1:0] idx_dn;
    logic [CNT_W-1:0] idx_up;
    logic             show_last;

    assign step_y = step_dec ? step_a - CNT_W'(1) : step_a + CNT_W'(1);
    assign idx_dn = idx_reg - CNT_W'(1);
    assign idx_up = idx_reg + CNT_W'(1);
    assign show_last = (idx_reg == len_reg);
    assign cmd_ready = (state_reg == S_IDLE);

    always_comb
    begin
        unique case (state_reg)
            S_INS_RD: raddr = idx_dn[ADDR_W-1:0];
            S_DEL_RD: raddr = idx_up[ADDR_W-1:0];
            default:  raddr = src_reg[ADDR_W-1:0];
        endcase
    end

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        cur_next    = cur_reg;
        idx_next    = idx_reg;
        src_next    = src_reg;
        status_next = status_reg;
        ch_next     = ch_reg;
        mem_we      = 1'b0;
        waddr       = idx_reg[ADDR_W-1:0];
        wdata       = rdata_reg;
        step_a      = cur_reg;
        step_dec    = 1'b1;
        res_push    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    ch_next     = cmd_ch;
                    status_next = ST_DONE;
                    state_next  = S_RESULT;
                    unique case (cmd_func)
                        FN_INSERT:
                        begin
                            if (len_reg >= CAP_CNT)
                                status_next = ST_FULL;
                            else
                            begin
                                idx_next   = len_reg;
                                state_next = S_INS_RD;
                            end
                        end
                        FN_BKSP:
                        begin
                            if (cur_reg == '0)
                                status_next = ST_BOUND;
                            else
                            begin
                                idx_next   = step_y;
                                cur_next   = step_y;
                                state_next = S_DEL_RD;
                            end
                        end
                        FN_DEL:
                        begin
                            if (cur_reg >= len_reg)
                                status_next = ST_BOUND;
                            else
                            begin
                                idx_next   = cur_reg;
                                state_next = S_DEL_RD;
                            end
                        end
                        FN_LEFT:
                        begin
                            if (cur_reg == '0)
                                status_next = ST_BOUND;
                            else
                                cur_next = step_y;
                        end
                        FN_RIGHT:
                        begin
                            step_dec = 1'b0;
                            if (cur_reg >= len_reg)
                                status_next = ST_BOUND;
                            else
                                cur_next = step_y;
                        end
                        FN_SHOW:
                        begin
                            idx_next   = '0;
                            src_next   = '0;
                            state_next = S_SHOW;
                        end
                        default: status_next = ST_BOUND;
                    endcase
                end
            end
            S_INS_RD:
            begin
                if (idx_reg > cur_reg)
                    state_next = S_INS_WR;
                else
                begin
                    mem_we     = 1'b1;
                    waddr      = cur_reg[ADDR_W-1:0];
                    wdata      = ch_reg;
                    step_dec   = 1'b0;
                    cur_next   = step_y;
                    len_next   = len_reg + CNT_W'(1);
                    state_next = S_RESULT;
                end
            end
            S_INS_WR:
            begin
                mem_we     = 1'b1;
                step_a     = idx_reg;
                idx_next   = step_y;
                state_next = S_INS_RD;
            end
            S_DEL_RD:
            begin
                if (idx_up < len_reg)
                    state_next = S_DEL_WR;
                else
                begin
                    len_next   = len_reg - CNT_W'(1);
                    state_next = S_RESULT;
                end
            end
            S_DEL_WR:
            begin
                mem_we     = 1'b1;
                step_a     = idx_reg;
                step_dec   = 1'b0;
                idx_next   = step_y;
                state_next = S_DEL_RD;
            end
            S_SHOW:
            begin
                if (idx_reg != cur_reg)
                    state_next = S_SHOW_DAT;
                else if (can_push)
                begin
                    res_push.push             = 1'b1;
                    res_push.word.text_byte   = MARK_BYTE;
                    res_push.word.is_cursor   = 1'b1;
                    res_push.word.last        = show_last;
                    res_push.word.line_length = len_reg;
                    res_push.word.cursor_pos  = cur_reg;
                    res_push.word.status      = ST_DONE;
                    step_a   = idx_reg;
                    step_dec = 1'b0;
                    idx_next = step_y;
                    state_next = show_last ? S_IDLE : S_SHOW;
                end
            end
            S_SHOW_DAT:
            begin
                if (can_push)
                begin
                    res_push.push             = 1'b1;
                    res_push.word.text_byte   = rdata_reg;
                    res_push.word.last        = show_last;
                    res_push.word.line_length = len_reg;
                    res_push.word.cursor_pos  = cur_reg;
                    res_push.word.status      = ST_DONE;
                    step_a   = idx_reg;
                    step_dec = 1'b0;
                    idx_next = step_y;
                    src_next = src_reg + CNT_W'(1);
                    state_next = show_last ? S_IDLE : S_SHOW;
                end
            end
            S_RESULT:
            begin
                if (can_push)
                begin
                    res_push.push             = 1'b1;
                    res_push.word.last        = 1'b1;
                    res_push.word.line_length = len_reg;
                    res_push.word.cursor_pos  = cur_reg;
                    res_push.word.status      = status_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            text_mem[waddr] <= wdata;
        rdata_reg <= text_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
            cur_reg    <= '0;
            idx_reg    <= '0;
            src_reg    <= '0;
            status_reg <= ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            cur_reg    <= cur_next;
            idx_reg    <= idx_next;
            src_reg    <= src_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg <= ch_next;
    end

endmodule

// ----- rtl/core/leb_out.sv -----
// Result output register between the sequencer and the result channel.
module leb_out import leb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  res_push_t res_push,
    output logic      can_push,
    input  logic      res_ready,
    output logic      res_valid,
    output res_word_t res_word
);

    logic      valid_reg, valid_next;
    res_word_t word_reg;

    assign can_push  = !valid_reg || res_ready;
    assign res_valid = valid_reg;
    assign res_word  = word_reg;

    always_comb
    begin
        priority if (res_push.push)
            valid_next = 1'b1;
        else if (res_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_push.push)
            word_reg <= res_push.word;
    end

endmodule

// ----- rtl/core/line_edit_buffer_with_cursor.sv -----
// Top level of the line edit buffer with cursor.
//
// cmd channel: one command word (func, ch) per handshake: insert, backspace,
// delete forward, cursor left/right, show. The block takes one command at a
// time; cmd.ready is low until every result word of that command is loaded
// into the output register.
// res channel: one word per edit or move command, line_length + 1 words for
// show (line bytes with a '#' marker at the cursor), last set on the final.
// Insert, backspace and delete shift the bytes from the cursor to the line
// end through the text memory, which has one registered read port and one
// write port: each shifted byte takes a read state and a write state.
// Reset clears length and cursor; text memory is not cleared.
// A stalled res.ready holds the output word and stops the sequencer when it next has a word to push.
module line_edit_buffer_with_cursor import leb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    leb_cmd_if.sink   cmd,
    leb_res_if.source res
);

    res_push_t res_push;
    res_word_t res_word;
    logic      can_push;

    leb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .cmd_func  (cmd.func),
        .cmd_ch    (cmd.ch),
        .can_push  (can_push),
        .res_push  (res_push)
    );

    leb_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_push  (res_push),
        .can_push  (can_push),
        .res_ready (res.ready),
        .res_valid (res.valid),
        .res_word  (res_word)
    );

    assign res.text_byte   = res_word.text_byte;
    assign res.is_cursor   = res_word.is_cursor;
    assign res.last        = res_word.last;
    assign res.line_length = res_word.line_length;
    assign res.cursor_pos  = res_word.cursor_pos;
    assign res.status      = res_word.status;

    a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready) |=> !cmd.ready)
        else $error("command taken while busy");

    a_marker_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.is_cursor) |-> (res.text_byte == MARK_BYTE && res.status == ST_DONE))
        else $error("bad cursor marker word");

    a_cursor_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.cursor_pos <= res.line_length && res.line_length <= CAP_CNT))
        else $error("cursor or length out of range");

    a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_push.push |-> can_push)
        else $error("result pushed into full output register");

endmodule
